// ===== sv/lmfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame buffer - shared definitions
// Operation codes, result kinds, field widths and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    // Fixed field widths
    localparam int OP_W     = 4;
    localparam int IDX_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int BMP_W    = 16;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 4;
    localparam int FRAME_SLOTS = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET_PIXEL   = 4'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE      = 4'd1;
    localparam logic [OP_W-1:0] OP_READ_PIXEL  = 4'd2;
    localparam logic [OP_W-1:0] OP_WRITE_ROW   = 4'd3;
    localparam logic [OP_W-1:0] OP_READ_ROW    = 4'd4;
    localparam logic [OP_W-1:0] OP_WRITE_COL   = 4'd5;
    localparam logic [OP_W-1:0] OP_FILL        = 4'd6;
    localparam logic [OP_W-1:0] OP_SCROLL      = 4'd7;
    localparam logic [OP_W-1:0] OP_DRAW_BITMAP = 4'd8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAM   = 2'd2;

    // Controller -> datapath
    typedef struct packed {
        logic exec;         // apply the accepted item's operation
        logic flush_start;  // restart the display RAM address
        logic flush_emit;   // load the next display RAM byte
    } lmfb_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;     // output register can take an item this cycle
        logic flush_last;   // current display RAM address is the final one
    } lmfb_status_t;

endpackage : lmfb_pkg
`default_nettype wire

// ===== sv/led_matrix_frame_buffer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame buffer unit
// 8x8 one-bit pixel frame with drawing, read-back and display RAM flush.
// ----------------------------------------------------------------------------
// Each item is one operation on a register frame of ROW_COUNT rows, cleared at
// reset. After a drawing or read operation the next item can be accepted the
// cycle after, as long as the output register is free (a read result not yet
// taken holds off the input). A flush item emits 2*ROW_COUNT display RAM
// bytes, one per cycle that the output side accepts; the flush sequencer reads
// one frame row per byte pair. The final result of every read or flush item
// carries m_tlast.
module led_matrix_frame_buffer_unit #(
    parameter int ROW_COUNT = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // row_index[2:0], col_index[5:3],
                                        // byte_value[13:6], bitmap_bits[29:14]
    input  wire logic [4:0]  s_tuser,   // operation[3:0], flush_request[4]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // ram_address[3:0], data_byte[11:4]
    output logic [1:0]       m_tuser,   // result_kind[1:0]
    output logic             m_tlast    // last_of_run
);
    import lmfb_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(2 * ROW_COUNT - 1);

    lmfb_cmd_t    cmd;
    lmfb_status_t status;

    logic [ADDR_W-1:0] ram_address;
    logic [BYTE_W-1:0] data_byte;

    lmfb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .flush_request (s_tuser[4]),
        .status        (status),
        .cmd           (cmd)
    );

    lmfb_datapath #(
        .ROW_COUNT (ROW_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .operation   (s_tuser[3:0]),
        .row_index   (s_tdata[2:0]),
        .col_index   (s_tdata[5:3]),
        .byte_value  (s_tdata[13:6]),
        .bitmap_bits (s_tdata[29:14]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .result_kind (m_tuser),
        .ram_address (ram_address),
        .data_byte   (data_byte),
        .last_of_run (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {4'b0000, data_byte, ram_address};

`ifndef SYNTHESIS
    // An item and a flush byte never compete for the output register
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && (cmd.flush_emit || cmd.flush_start)))
        else $error("item executed during flush");

    // A flush ends on the final display RAM address
    a_flush_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && (m_tuser == KIND_RAM)) |-> (ram_address == LAST_ADDR))
        else $error("flush ended at wrong address");

    // A read item yields a single final result in the next cycle
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[4] &&
         ((s_tuser[3:0] == OP_READ_PIXEL) || (s_tuser[3:0] == OP_READ_ROW)))
        |=> (m_tvalid && m_tlast && (ram_address == '0)))
        else $error("read result missing");
`endif

endmodule : led_matrix_frame_buffer_unit
`default_nettype wire

// ===== sv/lmfb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame buffer - controller
// Accepts items while idle and sequences the display RAM flush one byte per
// free output slot.
// ----------------------------------------------------------------------------
module lmfb_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  flush_request,
    input  wire lmfb_pkg::lmfb_status_t status,
    output lmfb_pkg::lmfb_cmd_t        cmd
);
    import lmfb_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // Input handshake and next-state logic
    always_comb begin
        s_tready         = (state_reg == ST_IDLE) && status.out_free;
        accept           = s_tvalid && s_tready;
        cmd.exec         = 1'b0;
        cmd.flush_start  = 1'b0;
        cmd.flush_emit   = 1'b0;
        state_next       = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (flush_request) begin
                        cmd.flush_start = 1'b1;
                        state_next      = ST_FLUSH;
                    end else begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.flush_emit = 1'b1;
                    if (status.flush_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : lmfb_ctrl
`default_nettype wire

// ===== sv/lmfb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame buffer - datapath
// Pixel frame registers with per-row update logic, the flush address counter
// and the output register.
// ----------------------------------------------------------------------------
module lmfb_datapath #(
    parameter int ROW_COUNT = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lmfb_pkg::lmfb_cmd_t           cmd,
    output lmfb_pkg::lmfb_status_t             status,
    input  wire logic [lmfb_pkg::OP_W-1:0]     operation,
    input  wire logic [lmfb_pkg::IDX_W-1:0]    row_index,
    input  wire logic [lmfb_pkg::IDX_W-1:0]    col_index,
    input  wire logic [lmfb_pkg::BYTE_W-1:0]   byte_value,
    input  wire logic [lmfb_pkg::BMP_W-1:0]    bitmap_bits,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [lmfb_pkg::KIND_W-1:0]        result_kind,
    output logic [lmfb_pkg::ADDR_W-1:0]        ram_address,
    output logic [lmfb_pkg::BYTE_W-1:0]        data_byte,
    output logic                               last_of_run
);
    import lmfb_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(2 * ROW_COUNT - 1);

    logic [BYTE_W-1:0] frame [FRAME_SLOTS];

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              valid_reg, valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ADDR_W-1:0] oaddr_reg, oaddr_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;

    logic [BYTE_W-1:0] sel_row;
    logic [BYTE_W-1:0] flush_row;
    logic [BYTE_W-1:0] flush_byte;

    // Frame rows: one register per row inside the frame, zero beyond it
    for (genvar r = 0; r < FRAME_SLOTS; r++) begin : g_row
        if (r < ROW_COUNT) begin : g_live
            logic [BYTE_W-1:0] row_reg, row_next;
            logic [IDX_W-1:0]  dr;
            logic [IDX_W-1:0]  dc;
            logic [3:0]        nib;
            logic              hit;

            always_comb begin
                row_next = row_reg;
                hit      = (row_index == IDX_W'(r));
                dr       = IDX_W'(r) - row_index;
                nib      = bitmap_bits[{dr[1:0], 2'b00} +: 4];
                dc       = '0;
                if (cmd.exec) begin
                    case (operation)
                        OP_SET_PIXEL:  if (hit) row_next[col_index] = byte_value[0];
                        OP_TOGGLE:     if (hit) row_next[col_index] = ~row_reg[col_index];
                        OP_WRITE_ROW:  if (hit) row_next = byte_value;
                        OP_WRITE_COL:  row_next[col_index] = byte_value[r];
                        OP_FILL:       row_next = {BYTE_W{byte_value[0]}};
                        OP_SCROLL:     row_next = {byte_value[r], row_reg[BYTE_W-1:1]};
                        OP_DRAW_BITMAP: begin
                            // clipped 4x4 stamp; rows past the frame do not exist
                            if ((IDX_W'(r) >= row_index) && (dr < IDX_W'(4))) begin
                                for (int c = 0; c < BYTE_W; c++) begin
                                    dc = IDX_W'(c) - col_index;
                                    if ((IDX_W'(c) >= col_index) && (dc < IDX_W'(4))) begin
                                        row_next[c] = nib[dc[1:0]];
                                    end
                                end
                            end
                        end
                        default: row_next = row_reg;
                    endcase
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    row_reg <= '0;
                end else begin
                    row_reg <= row_next;
                end
            end

            assign frame[r] = row_reg;
        end else begin : g_void
            assign frame[r] = '0;
        end
    end

    // Read selection and display RAM byte (row rotated right by one, odd: zero)
    assign sel_row    = frame[row_index];
    assign flush_row  = frame[addr_reg[ADDR_W-1:1]];
    assign flush_byte = addr_reg[0] ? '0 : {flush_row[0], flush_row[BYTE_W-1:1]};

    assign status.out_free   = !valid_reg || m_tready;
    assign status.flush_last = (addr_reg == LAST_ADDR);

    // Flush address counter and output register
    always_comb begin
        addr_next  = addr_reg;
        valid_next = valid_reg && !m_tready;
        kind_next  = kind_reg;
        oaddr_next = oaddr_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (cmd.flush_start) begin
            addr_next = '0;
        end
        if (cmd.flush_emit) begin
            addr_next  = addr_reg + ADDR_W'(1);
            valid_next = 1'b1;
            kind_next  = KIND_RAM;
            oaddr_next = addr_reg;
            data_next  = flush_byte;
            last_next  = status.flush_last;
        end
        if (cmd.exec) begin
            case (operation)
                OP_READ_PIXEL: begin
                    valid_next = 1'b1;
                    kind_next  = KIND_PIXEL;
                    oaddr_next = '0;
                    data_next  = BYTE_W'(sel_row[col_index]);
                    last_next  = 1'b1;
                end
                OP_READ_ROW: begin
                    valid_next = 1'b1;
                    kind_next  = KIND_ROW;
                    oaddr_next = '0;
                    data_next  = sel_row;
                    last_next  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            addr_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            addr_reg  <= addr_next;
        end
        kind_reg  <= kind_next;
        oaddr_reg <= oaddr_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
    end

    assign m_tvalid    = valid_reg;
    assign result_kind = kind_reg;
    assign ram_address = oaddr_reg;
    assign data_byte   = data_reg;
    assign last_of_run = last_reg;

endmodule : lmfb_datapath
`default_nettype wire

// ===== sim/led_matrix_frame_buffer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame buffer unit - testbench
// Drives drawing, read-back and flush items into the stream input, directed,
// then in random sender bursts, with receiver stalls throughout. A scoreboard
// keeps its own copy of the pixel frame and checks every result item, field-wise.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_unit_tb;
    import lmfb_pkg::*;

    localparam int ROW_COUNT   = 8;
    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 6;
    localparam int RANDOM_ITEMS = 400;

    // Opcodes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd9;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

    // One input item
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [BYTE_W-1:0] value;
        logic [BMP_W-1:0]  bitmap;
        logic              flush;
    } frame_cmd_t;

    // One result item
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_out_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow frame plus queue of results still owed by the block
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [BYTE_W-1:0] shadow_frame [FRAME_SLOTS];
        frame_out_t        owed_results [$];
        int                mismatches;

        function new();
            foreach (shadow_frame[r]) shadow_frame[r] = '0;
            mismatches = 0;
        endfunction

        function void owe(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                          logic [BYTE_W-1:0] data, logic last);
            frame_out_t o;
            o.kind = kind;
            o.addr = addr;
            o.data = data;
            o.last = last;
            owed_results.push_back(o);
        endfunction

        // Update the shadow frame for an accepted item, queue its results
        function void apply_item(frame_cmd_t c);
            logic [BYTE_W-1:0] b;
            logic              in_frame;
            int                fr;
            int                fc;
            in_frame = int'(c.row) < ROW_COUNT;
            if (c.flush) begin
                // each row rotated right by one, then a zero byte
                for (int r = 0; r < ROW_COUNT; r++) begin
                    b = shadow_frame[r];
                    owe(KIND_RAM, ADDR_W'(2 * r), {b[0], b[7:1]}, 1'b0);
                    owe(KIND_RAM, ADDR_W'(2 * r + 1), '0, r == ROW_COUNT - 1);
                end
                return;
            end
            case (c.op)
                OP_SET_PIXEL:
                    if (in_frame) shadow_frame[c.row][c.col] = c.value[0];
                OP_TOGGLE:
                    if (in_frame) shadow_frame[c.row][c.col] = ~shadow_frame[c.row][c.col];
                OP_READ_PIXEL:
                    owe(KIND_PIXEL, '0,
                        in_frame ? BYTE_W'(shadow_frame[c.row][c.col]) : '0, 1'b1);
                OP_WRITE_ROW:
                    if (in_frame) shadow_frame[c.row] = c.value;
                OP_READ_ROW:
                    owe(KIND_ROW, '0, in_frame ? shadow_frame[c.row] : '0, 1'b1);
                OP_WRITE_COL:
                    for (int r = 0; r < ROW_COUNT; r++)
                        shadow_frame[r][c.col] = c.value[r];
                OP_FILL:
                    for (int r = 0; r < ROW_COUNT; r++)
                        shadow_frame[r] = c.value[0] ? 8'hFF : 8'h00;
                OP_SCROLL:
                    for (int r = 0; r < ROW_COUNT; r++)
                        shadow_frame[r] = {c.value[r], shadow_frame[r][7:1]};
                OP_DRAW_BITMAP:
                    // clipped at the bottom and right edges
                    for (int r = 0; r < 4; r++) begin
                        fr = int'(c.row) + r;
                        if (fr >= ROW_COUNT) break;
                        for (int k = 0; k < 4; k++) begin
                            fc = int'(c.col) + k;
                            if (fc >= 8) break;
                            shadow_frame[fr][fc] = c.bitmap[4 * r + k];
                        end
                    end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Check one accepted result against the oldest owed one
        function void check_output(frame_out_t got);
            frame_out_t want;
            if (owed_results.size() == 0) begin
                $display({"%0t ns: unexpected result, expected none, ",
                          "actual kind %0h addr %0h data %0h last %0b"},
                         $time, got.kind, got.addr, got.data, got.last);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(got.kind));
            compare_field("ram_address", 32'(want.addr), 32'(got.addr));
            compare_field("data_byte", 32'(want.data), 32'(got.data));
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    frame_scoreboard frame_check = new();

    led_matrix_frame_buffer_unit #(
        .ROW_COUNT (ROW_COUNT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    function automatic frame_cmd_t make_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                            logic [IDX_W-1:0] col, logic [BYTE_W-1:0] value,
                                            logic [BMP_W-1:0] bitmap, logic flush);
        frame_cmd_t c;
        c.op     = op;
        c.row    = row;
        c.col    = col;
        c.value  = value;
        c.bitmap = bitmap;
        c.flush  = flush;
        return c;
    endfunction

    // Present one item and hold it until accepted
    task automatic send_item(frame_cmd_t c);
        @(negedge aclk);
        s_tdata  <= {2'b00, c.bitmap, c.value, c.col, c.row};
        s_tuser  <= {c.flush, c.op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        frame_check.apply_item(c);
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 5'($urandom);
        end
    endtask

    // Mostly legal drawing and read traffic, some flushes and spare opcodes
    function automatic frame_cmd_t random_cmd();
        frame_cmd_t c;
        c.op     = ($urandom_range(0, 19) == 0) ?
                   OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)) :
                   OP_W'($urandom_range(OP_SET_PIXEL, OP_DRAW_BITMAP));
        c.row    = IDX_W'($urandom);
        c.col    = IDX_W'($urandom);
        c.value  = BYTE_W'($urandom);
        c.bitmap = BMP_W'($urandom);
        c.flush  = ($urandom_range(0, 99) < 7);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stalls in phases of always ready, random and mostly stalled
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 40);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        frame_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.addr = m_tdata[3:0];
            got.data = m_tdata[11:4];
            got.last = m_tlast;
            frame_check.check_output(got);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        frame_cmd_t c;
        int         accepted;
        int         burst;
        int         gap;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: flush of a cleared frame, fills, pixel edges, clipping
        send_item(make_cmd(OP_READ_ROW, 3'd7, 3'd0, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_SET_PIXEL, 3'd0, 3'd0, 8'h00, 16'h0000, 1'b1));
        send_item(make_cmd(OP_FILL, 3'd0, 3'd0, 8'hFF, 16'hFFFF, 1'b0));
        send_item(make_cmd(OP_READ_PIXEL, 3'd7, 3'd7, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_SET_PIXEL, 3'd0, 3'd0, 8'hFE, 16'h0000, 1'b0));
        send_item(make_cmd(OP_READ_ROW, 3'd0, 3'd0, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_FILL, 3'd7, 3'd7, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_SET_PIXEL, 3'd7, 3'd7, 8'h01, 16'h0000, 1'b0));
        send_item(make_cmd(OP_TOGGLE, 3'd3, 3'd5, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_TOGGLE, 3'd7, 3'd7, 8'hFF, 16'h0000, 1'b0));
        send_item(make_cmd(OP_WRITE_ROW, 3'd5, 3'd0, 8'hA5, 16'h0000, 1'b0));
        send_item(make_cmd(OP_WRITE_ROW, 3'd0, 3'd0, 8'hFF, 16'h0000, 1'b0));
        send_item(make_cmd(OP_WRITE_COL, 3'd0, 3'd7, 8'h81, 16'h0000, 1'b0));
        send_item(make_cmd(OP_WRITE_COL, 3'd0, 3'd0, 8'hFF, 16'h0000, 1'b0));
        send_item(make_cmd(OP_SCROLL, 3'd0, 3'd0, 8'h55, 16'h0000, 1'b0));
        send_item(make_cmd(OP_DRAW_BITMAP, 3'd6, 3'd6, 8'h00, 16'hFFFF, 1'b0));
        send_item(make_cmd(OP_DRAW_BITMAP, 3'd0, 3'd0, 8'h00, 16'h5A3C, 1'b0));
        send_item(make_cmd(OP_DRAW_BITMAP, 3'd7, 3'd5, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_READ_ROW, 3'd6, 3'd0, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_SPARE_FIRST, 3'd1, 3'd1, 8'hFF, 16'hFFFF, 1'b0));
        send_item(make_cmd(OP_SPARE_LAST, 3'd7, 3'd7, 8'hFF, 16'hFFFF, 1'b0));
        send_item(make_cmd(OP_READ_PIXEL, 3'd3, 3'd5, 8'h00, 16'h0000, 1'b0));
        send_item(make_cmd(OP_SPARE_LAST, 3'd7, 3'd7, 8'hFF, 16'hFFFF, 1'b1));

        // Random bursts
        accepted = 0;
        while (accepted < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                c = random_cmd();
                send_item(c);
                accepted++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            idle_input(gap);
        end

        // Final flush so the last frame state is read out, then drain
        send_item(make_cmd(OP_SET_PIXEL, 3'd0, 3'd0, 8'h00, 16'h0000, 1'b1));
        idle_input(1);
        while (frame_check.owed_results.size() != 0) @(posedge aclk);
        repeat (4 * ROW_COUNT) @(posedge aclk);

        if (frame_check.mismatches == 0 && frame_check.owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lmfb_pkg.sv
sv/lmfb_ctrl.sv
sv/lmfb_datapath.sv
sv/led_matrix_frame_buffer_unit.sv
sim/led_matrix_frame_buffer_unit_tb.sv
